FILE: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

  localparam int DEF_MAX_BLOCKS      = 256;
  localparam int DEF_MAX_BLOCK_BYTES = 4096;

  // Port field widths
  localparam int OPC_W    = 2;
  localparam int REQ_W    = 16;
  localparam int OFF_W    = 20;
  localparam int STAT_W   = 3;
  localparam int GSIZE_W  = 13;
  localparam int ALIGN_W  = 9;
  localparam int CNT_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Block size after rounding can reach the byte limit, 4096 by default
  localparam int SIZE_W = 14;
  localparam int DIV_STEPS = OFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPC_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_RESET = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_PTR   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NULL      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  localparam logic [12:0] RST_BLOCK_SIZE  = 13'd64;
  localparam logic [8:0]  RST_BLOCK_ALIGN = 9'd8;
  localparam logic [8:0]  RST_BLOCK_COUNT = 9'd256;

  typedef enum logic [2:0] {
    S_PREP,
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_ALLOC_WB,
    S_DIV,
    S_FREE_WB
  } state_t;

endpackage

FILE: rtl/core/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator. Pulse start while busy is low to issue one
// operation (allocate, free, reset pool); exactly one result beat follows on
// out_valid, which must be taken that cycle since it cannot be held off.
// An allocate answers from the alloc write-back state after decode; ops that
// fail early and opcode 3 answer from decode; a free answers from its write-back
// state once a 20-step restoring divider has checked the offset, one quotient
// bit a cycle. Pool reset answers from decode, then keeps busy high while the
// link memory is rewritten one entry a cycle. Out of reset, and after a write to
// any of the three defined registers, busy covers prep and the same relink
// pass; config writes are always taken and abort any pending op with no result.
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  start,
  output logic                  busy,
  input  logic [OPC_W-1:0]      in_opcode,
  input  logic [REQ_W-1:0]      in_request_size,
  input  logic                  in_free_is_null,
  input  logic [OFF_W-1:0]      in_free_offset,

  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [OFF_W-1:0]      out_block_offset,
  output logic [GSIZE_W-1:0]    out_granted_size,
  output logic [ALIGN_W-1:0]    out_granted_alignment,
  output logic [CNT_W-1:0]      out_used_count,
  output logic [CNT_W-1:0]      out_peak_count,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = LINK_W + SIZE_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_BLOCKS - 1);

  function automatic logic [ALIGN_W-1:0] calc_align(input logic [8:0] a);
    logic [ALIGN_W-1:0] p;
    p = ALIGN_W'(256);
    for (int k = 8; k >= 0; k--) begin
      if ((9'd1 << k) >= a) p = ALIGN_W'(9'd1 << k);
    end
    return p;
  endfunction

  function automatic logic [SIZE_W-1:0] calc_size(input logic [12:0] s,
                                                  input logic [ALIGN_W-1:0] a);
    logic [12:0]       s1;
    logic [12:0]       s2;
    logic [SIZE_W-1:0] mask;
    logic [SIZE_W-1:0] sum;
    s1   = (s == 13'd0) ? 13'd1 : s;
    s2   = (32'(s1) > MAX_BLOCK_BYTES) ? 13'(MAX_BLOCK_BYTES) : s1;
    mask = SIZE_W'(a) - SIZE_W'(1);
    sum  = SIZE_W'(s2) + mask;
    return sum & ~mask;
  endfunction

  function automatic logic [LINK_W-1:0] calc_count(input logic [8:0] c);
    logic [8:0] c1;
    c1 = (c == 9'd0) ? 9'd1 : c;
    if (32'(c1) > MAX_BLOCKS) return LINK_W'(MAX_BLOCKS);
    return LINK_W'(c1);
  endfunction

  state_t state_r, state_nxt;

  logic [12:0]          cfg_size_r,  cfg_size_nxt;
  logic [8:0]           cfg_align_r, cfg_align_nxt;
  logic [8:0]           cfg_count_r, cfg_count_nxt;

  logic [SIZE_W-1:0]    size_r;
  logic [ALIGN_W-1:0]   align_r;
  logic [LINK_W-1:0]    count_r;

  logic [LINK_W-1:0]    head_r,  head_nxt;
  logic [LINK_W-1:0]    used_r,  used_nxt;
  logic [LINK_W-1:0]    peak_r,  peak_nxt;
  logic [IDX_W-1:0]     sweep_r, sweep_nxt;

  logic [OPC_W-1:0]     op_r,      op_nxt;
  logic [REQ_W-1:0]     req_r,     req_nxt;
  logic                 is_null_r, is_null_nxt;
  logic [OFF_W-1:0]     off_r,     off_nxt;

  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [SIZE_W-1:0]    rem_r,  rem_nxt;
  logic [OFF_W-1:0]     quo_r,  quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [OFF_W-1:0]     boff_r,   boff_nxt;
  logic [GSIZE_W-1:0]   gsize_r,  gsize_nxt;
  logic [ALIGN_W-1:0]   galign_r, galign_nxt;

  // Link memory
  logic [LINK_W-1:0]    link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]    link_rd_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [LINK_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic [LINK_W-1:0]    mul_a;
  logic [LINK_W-1:0]    sweep_inc;
  logic [LINK_W-1:0]    used_inc;
  logic [SIZE_W:0]      div_shift;
  logic                 div_ge;

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    link_rd_r <= link_mem[mem_raddr];
  end

  // Effective configuration, registered once more behind the registers; the prep
  // state covers that lag before any relink.
  always_ff @(posedge clk) begin
    align_r <= calc_align(cfg_align_r);
    size_r  <= calc_size(cfg_size_r, calc_align(cfg_align_r));
    count_r <= calc_count(cfg_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PREP;
      cfg_size_r  <= RST_BLOCK_SIZE;
      cfg_align_r <= RST_BLOCK_ALIGN;
      cfg_count_r <= RST_BLOCK_COUNT;
      head_r      <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      sweep_r     <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_size_r  <= cfg_size_nxt;
      cfg_align_r <= cfg_align_nxt;
      cfg_count_r <= cfg_count_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      sweep_r     <= sweep_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    is_null_r <= is_null_nxt;
    off_r     <= off_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    status_r  <= status_nxt;
    boff_r    <= boff_nxt;
    gsize_r   <= gsize_nxt;
    galign_r  <= galign_nxt;
  end

  assign mul_a     = (op_r == OP_ALLOC) ? head_r : count_r;
  assign sweep_inc = LINK_W'(sweep_r) + LINK_W'(1);
  assign used_inc  = (used_r < count_r) ? used_r + LINK_W'(1) : used_r;
  assign div_shift = {rem_r, quo_r[OFF_W-1]};
  assign div_ge    = (div_shift >= {1'b0, size_r});

  always_comb begin
    state_nxt     = state_r;
    cfg_size_nxt  = cfg_size_r;
    cfg_align_nxt = cfg_align_r;
    cfg_count_nxt = cfg_count_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    peak_nxt      = peak_r;
    sweep_nxt     = sweep_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    is_null_nxt   = is_null_r;
    off_nxt       = off_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    boff_nxt      = boff_r;
    gsize_nxt     = gsize_r;
    galign_nxt    = galign_r;
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = (sweep_inc < count_r) ? sweep_inc : NULL_LINK;
    mem_raddr     = head_r[IDX_W-1:0];

    unique case (state_r)
      S_PREP: begin
        sweep_nxt = '0;
        state_nxt = S_SWEEP;
      end

      S_SWEEP: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + IDX_W'(1);
        if (sweep_r == LAST_IDX) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          op_nxt      = in_opcode;
          req_nxt     = in_request_size;
          is_null_nxt = in_free_is_null;
          off_nxt     = in_free_offset;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        boff_nxt   = '0;
        gsize_nxt  = '0;
        galign_nxt = '0;
        prod_nxt   = PROD_W'(mul_a) * PROD_W'(size_r);
        rem_nxt    = '0;
        quo_nxt    = off_r;
        div_cnt_nxt = '0;
        case (op_r)
          OP_ALLOC: begin
            if (req_r > REQ_W'(size_r)) begin
              status_nxt    = ST_TOO_LARGE;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (head_r >= NULL_LINK) begin
              status_nxt    = ST_EXHAUSTED;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_ALLOC_WB;
            end
          end
          OP_FREE: begin
            if (is_null_r) begin
              status_nxt    = ST_NULL;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_DIV;
            end
          end
          OP_RESET: begin
            head_nxt      = '0;
            used_nxt      = '0;
            peak_nxt      = '0;
            out_valid_nxt = 1'b1;
            sweep_nxt     = '0;
            state_nxt     = S_SWEEP;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_ALLOC_WB: begin
        head_nxt      = link_rd_r;
        used_nxt      = used_inc;
        if (used_inc > peak_r) peak_nxt = used_inc;
        boff_nxt      = OFF_W'(prod_r);
        gsize_nxt     = GSIZE_W'(size_r);
        galign_nxt    = align_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_DIV: begin
        rem_nxt     = div_ge ? SIZE_W'(div_shift - {1'b0, size_r})
                             : SIZE_W'(div_shift);
        quo_nxt     = {quo_r[OFF_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_FREE_WB;
      end

      S_FREE_WB: begin
        // quotient is below block count whenever the offset is in the pool
        if ((32'(off_r) >= 32'(prod_r)) || (rem_r != '0)) begin
          status_nxt = ST_BAD_PTR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = quo_r[IDX_W-1:0];
          mem_wdata = head_r;
          head_nxt  = LINK_W'(quo_r[IDX_W-1:0]);
          if (used_r != '0) used_nxt = used_r - LINK_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_PREP;
    endcase

    // A write to any of the three defined registers rebuilds the pool
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: begin
          cfg_size_nxt = cfg_data;
          state_nxt    = S_PREP;
        end
        CFG_BLOCK_ALIGN: begin
          cfg_align_nxt = cfg_data[8:0];
          state_nxt     = S_PREP;
        end
        CFG_BLOCK_COUNT: begin
          cfg_count_nxt = cfg_data[8:0];
          state_nxt     = S_PREP;
        end
        default: ;
      endcase
      if (cfg_index == CFG_BLOCK_SIZE || cfg_index == CFG_BLOCK_ALIGN ||
          cfg_index == CFG_BLOCK_COUNT) begin
        head_nxt      = '0;
        used_nxt      = '0;
        peak_nxt      = '0;
        mem_we        = 1'b0;
        out_valid_nxt = 1'b0;
      end
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_block_offset      = boff_r;
  assign out_granted_size      = gsize_r;
  assign out_granted_alignment = galign_r;
  assign out_used_count        = CNT_W'(used_r);
  assign out_peak_count        = CNT_W'(peak_r);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import fbpa_pkg::*;
();

  localparam logic [OPC_W-1:0]     OP_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
  localparam int unsigned          LINK_NULL      = DEF_MAX_BLOCKS;
  localparam int unsigned          ALIGN_CAP      = 256;
  localparam int unsigned          ITEM_TARGET    = 750;
  localparam int unsigned          WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [OFF_W-1:0]   offset;
    logic [GSIZE_W-1:0] gsize;
    logic [ALIGN_W-1:0] galign;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   peak;
  } pool_reply_t;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [OPC_W-1:0]      in_opcode       = '0;
  logic [REQ_W-1:0]      in_request_size = '0;
  logic                  in_free_is_null = 1'b0;
  logic [OFF_W-1:0]      in_free_offset  = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [OFF_W-1:0]      out_block_offset;
  logic [GSIZE_W-1:0]    out_granted_size;
  logic [ALIGN_W-1:0]    out_granted_alignment;
  logic [CNT_W-1:0]      out_used_count;
  logic [CNT_W-1:0]      out_peak_count;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  fixed_block_pool_allocator_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_request_size      (in_request_size),
    .in_free_is_null      (in_free_is_null),
    .in_free_offset       (in_free_offset),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_block_offset     (out_block_offset),
    .out_granted_size     (out_granted_size),
    .out_granted_alignment(out_granted_alignment),
    .out_used_count       (out_used_count),
    .out_peak_count       (out_peak_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // shadow pool state
  logic [GSIZE_W-1:0] reg_size;
  logic [ALIGN_W-1:0] reg_align;
  logic [CNT_W-1:0]   reg_count;
  int unsigned        link_mem [DEF_MAX_BLOCKS];
  int unsigned        free_head_m;
  int unsigned        used_m;
  int unsigned        peak_m;

  pool_reply_t        expected_replies [$];
  logic [OFF_W-1:0]   held_offsets [$];
  int unsigned        ops_sent     = 0;
  int unsigned        idle_pct     = 0;
  int unsigned        errors       = 0;
  int unsigned        stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pool_align();
    int unsigned a;
    int unsigned p;
    a = 32'(reg_align);
    if (a > ALIGN_CAP) a = ALIGN_CAP;
    p = 1;
    while (p < a) p = p << 1;
    return p;
  endfunction

  function automatic int unsigned pool_block_bytes();
    int unsigned s;
    int unsigned a;
    s = 32'(reg_size);
    a = pool_align();
    if (s == 0) s = 1;
    if (s > DEF_MAX_BLOCK_BYTES) s = DEF_MAX_BLOCK_BYTES;
    return (s + a - 1) & ~(a - 1);
  endfunction

  function automatic int unsigned pool_count();
    int unsigned c;
    c = 32'(reg_count);
    if (c == 0) c = 1;
    if (c > DEF_MAX_BLOCKS) c = DEF_MAX_BLOCKS;
    return c;
  endfunction

  function automatic void relink_pool();
    int unsigned n;
    n = pool_count();
    for (int i = 0; i < DEF_MAX_BLOCKS; i++) link_mem[i] = (i + 1 < n) ? i + 1 : LINK_NULL;
    free_head_m = 0;
    used_m      = 0;
    peak_m      = 0;
    held_offsets.delete();
  endfunction

  function automatic void apply_cfg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BLOCK_SIZE:  reg_size  = data;
      CFG_BLOCK_ALIGN: reg_align = data[ALIGN_W-1:0];
      CFG_BLOCK_COUNT: reg_count = data[CNT_W-1:0];
      default:         return;
    endcase
    relink_pool();
  endfunction

  function automatic pool_reply_t predict_pool_op(logic [OPC_W-1:0] op, logic [REQ_W-1:0] req,
                                                  logic nul, logic [OFF_W-1:0] off);
    pool_reply_t r;
    int unsigned sz;
    int unsigned al;
    int unsigned cnt;
    int unsigned blk;
    sz = pool_block_bytes();
    al = pool_align();
    cnt = pool_count();
    r.status = ST_OK;
    r.offset = '0;
    r.gsize  = '0;
    r.galign = '0;
    case (op)
      OP_ALLOC: begin
        if (req > sz) begin
          r.status = ST_TOO_LARGE;
        end else if (free_head_m >= LINK_NULL) begin
          r.status = ST_EXHAUSTED;
        end else begin
          blk = free_head_m;
          free_head_m = link_mem[blk];
          if (used_m < cnt) used_m++;
          if (used_m > peak_m) peak_m = used_m;
          r.offset = OFF_W'(blk * sz);
          r.gsize  = GSIZE_W'(sz);
          r.galign = ALIGN_W'(al);
        end
      end
      OP_FREE: begin
        if (nul) begin
          r.status = ST_NULL;
        end else if (off >= cnt * sz || off % sz != 0) begin
          r.status = ST_BAD_PTR;
        end else begin
          // no double-free guard: the block is pushed again
          blk = off / sz;
          link_mem[blk] = free_head_m;
          free_head_m = blk;
          if (used_m > 0) used_m--;
        end
      end
      OP_RESET: relink_pool();
      default: ;
    endcase
    r.used = CNT_W'(used_m);
    r.peak = CNT_W'(peak_m);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : reply_check
    pool_reply_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d", $time, out_status);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("block_offset", 32'(want.offset), 32'(out_block_offset));
        check_field("granted_size", 32'(want.gsize), 32'(out_granted_size));
        check_field("granted_alignment", 32'(want.galign), 32'(out_granted_alignment));
        check_field("used_count", 32'(want.used), 32'(out_used_count));
        check_field("peak_count", 32'(want.peak), 32'(out_peak_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // start is left high after the beat so back-to-back ops need no toggle
  task automatic send_op(logic [OPC_W-1:0] op, logic [REQ_W-1:0] req, logic nul,
                         logic [OFF_W-1:0] off);
    pool_reply_t r;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_request_size <= req;
    in_free_is_null <= nul;
    in_free_offset  <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_pool_op(op, req, nul, off);
    expected_replies.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) held_offsets.push_back(r.offset);
    ops_sent++;
  endtask

  task automatic drain_pool();
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    // a pool reset keeps relinking after its beat
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_pool();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_default_pool();
    send_op(OP_ALLOC, 16'd0, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'd64, 1'b1, 20'hFFFFF);
    send_op(OP_ALLOC, 16'd65, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'hFFFF, 1'b0, 20'd0);
    send_op(OP_FREE, 16'd0, 1'b1, 20'hFFFFF);
    send_op(OP_FREE, 16'd0, 1'b0, 20'd1);
    send_op(OP_FREE, 16'd0, 1'b0, 20'(256 * 64));
    send_op(OP_FREE, 16'hFFFF, 1'b0, 20'd64);
    send_op(OP_UNUSED, 16'hFFFF, 1'b1, 20'hFFFFF);
    send_op(OP_RESET, 16'd0, 1'b0, 20'd0);
    // last block freed with nothing in use: count stays at zero
    send_op(OP_FREE, 16'd0, 1'b0, 20'(255 * 64));
  endtask

  task automatic test_register_clamps();
    write_reg(CFG_BLOCK_SIZE, 13'd0);
    write_reg(CFG_BLOCK_ALIGN, 13'd0);
    write_reg(CFG_BLOCK_COUNT, 13'd0);
    send_op(OP_ALLOC, 16'd1, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'd0, 1'b0, 20'd0);
    write_reg(CFG_BLOCK_SIZE, 13'h1FFF);
    write_reg(CFG_BLOCK_ALIGN, 13'h1FFF);
    write_reg(CFG_BLOCK_COUNT, 13'h1FFF);
    send_op(OP_ALLOC, 16'd4096, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'd4097, 1'b0, 20'd0);
    send_op(OP_FREE, 16'd0, 1'b0, 20'(255 * 4096));
  endtask

  task automatic test_double_free();
    write_reg(CFG_BLOCK_COUNT, 13'd1);
    send_op(OP_ALLOC, 16'd0, 1'b0, 20'd0);
    send_op(OP_FREE, 16'd0, 1'b0, 20'd0);
    send_op(OP_FREE, 16'd0, 1'b0, 20'd0);
    // block 0 now links to itself
    send_op(OP_ALLOC, 16'd0, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'd0, 1'b0, 20'd0);
  endtask

  task automatic test_alignment_rounding();
    write_reg(CFG_BLOCK_COUNT, 13'd8);
    write_reg(CFG_BLOCK_SIZE, 13'd100);
    write_reg(CFG_BLOCK_ALIGN, 13'd3);
    send_op(OP_ALLOC, 16'd100, 1'b0, 20'd0);
    write_reg(CFG_BLOCK_ALIGN, 13'd100);
    send_op(OP_ALLOC, 16'd128, 1'b0, 20'd0);
    send_op(OP_ALLOC, 16'd129, 1'b0, 20'd0);
  endtask

  task automatic test_unused_register();
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_op(OP_ALLOC, 16'd1, 1'b0, 20'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned sz;
    int unsigned cnt;
    int unsigned pick;
    int unsigned k;
    logic [OPC_W-1:0]      op;
    logic [REQ_W-1:0]      req;
    logic                  nul;
    logic [OFF_W-1:0]      off;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    while (ops_sent < ITEM_TARGET) begin
      repeat ($urandom_range(1, 3)) begin
        idx = ($urandom_range(0, 19) == 0) ? CFG_UNUSED : CFG_IDX_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        data = CFG_DATA_W'($urandom_range(0, 13'h1FFF));
        case (idx)
          CFG_BLOCK_SIZE: begin
            if (pick == 0) data = '0;
            else if (pick < 6) data = CFG_DATA_W'($urandom_range(1, 64));
            else if (pick < 9) data = CFG_DATA_W'($urandom_range(65, DEF_MAX_BLOCK_BYTES));
          end
          CFG_BLOCK_ALIGN: begin
            if (pick < 3) data = CFG_DATA_W'($urandom_range(0, 511));
            else if (pick < 9) data = CFG_DATA_W'(1 << $urandom_range(0, 8));
          end
          CFG_BLOCK_COUNT: begin
            if (pick < 7) data = CFG_DATA_W'($urandom_range(1, 12));
            else if (pick < 9) data = CFG_DATA_W'($urandom_range(13, 511));
          end
          default: ;
        endcase
        idle_pct = 0;
        write_reg(idx, data);
      end
      if (ops_sent + 120 > ITEM_TARGET) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      repeat ($urandom_range(20, 60)) begin
        sz  = pool_block_bytes();
        cnt = pool_count();
        op  = OP_UNUSED;
        req = REQ_W'($urandom_range(0, 16'hFFFF));
        nul = 1'($urandom_range(0, 1));
        off = OFF_W'($urandom_range(0, 20'hFFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          op = OP_ALLOC;
          case ($urandom_range(0, 9))
            0:       ;
            1:       req = REQ_W'(sz + $urandom_range(1, 16));
            default: req = REQ_W'($urandom_range(0, sz));
          endcase
        end else if (pick < 85) begin
          op  = OP_FREE;
          nul = 1'b0;
          if (held_offsets.size() != 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, held_offsets.size() - 1);
            off = held_offsets[k];
            held_offsets.delete(k);
          end else begin
            case ($urandom_range(0, 4))
              0:       nul = 1'b1;
              1:       ;
              2:       off = OFF_W'($urandom_range(0, cnt - 1) * sz +
                                    $urandom_range(1, (sz > 1) ? sz - 1 : 1));
              3:       off = OFF_W'(cnt * sz);
              default: off = OFF_W'($urandom_range(0, cnt - 1) * sz);
            endcase
          end
        end else if (pick < 92) begin
          op = OP_RESET;
        end
        send_op(op, req, nul, off);
      end
      drain_pool();
    end
  endtask

  initial begin
    reg_size  = RST_BLOCK_SIZE;
    reg_align = RST_BLOCK_ALIGN;
    reg_count = RST_BLOCK_COUNT;
    relink_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_default_pool();
    test_register_clamps();
    test_double_free();
    test_alignment_rounding();
    test_unused_register();
    test_random_traffic();

    drain_pool();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
